/* hdl/jsu_pkg.sv */
// Shared types and constants of the JSON string unescaper.
// Holds the decoder state record, the result record and the status codes.
// No dependencies.
package jsu_pkg;

    // Decoded length limit: register width and saturating counter width.
    localparam int LEN_W     = 24;
    localparam int LEN_CNT_W = LEN_W + 1;
    localparam int CFG_W     = 24;
    localparam logic [CFG_W-1:0] MAX_RESET_CFG = 24'h100000;

    // Results one input byte can cause at most (seven are ever used).
    localparam int RES_DEPTH = 8;
    localparam int RES_IDX_W = $clog2(RES_DEPTH);

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_CLOSED   = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_BAD_UNI  = 3'd3;
    localparam logic [2:0] ST_BAD_ESC  = 3'd4;
    localparam logic [2:0] ST_CTRL     = 3'd5;
    localparam logic [2:0] ST_TOO_LONG = 3'd6;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_BODY = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [11:0]          acc;     // hex digits gathered so far
        logic [1:0]           cnt;     // number of hex digits gathered
        logic                 pend;    // high surrogate waiting for its partner
        logic [9:0]           saved;   // payload bits of that high surrogate
        logic [LEN_CNT_W-1:0] len;     // decoded length, saturating
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic [2:0] status;
    } res_t;

endpackage

/* hdl/jsu_decode.sv */
// Single-pass decode step of the JSON string unescaper.
// Maps one input byte and the current state to its result list and next state.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  state_t                     state_cur,
    input  logic [7:0]                 text_byte,
    input  logic                       start_of_string,
    input  logic                       end_of_text,
    input  logic [LEN_W-1:0]           max_len,
    output state_t                     state_next,
    output res_t [RES_DEPTH-1:0]       results,
    output logic [RES_IDX_W-1:0]       res_count
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_TOP = 8'h20;
    localparam logic [20:0] CP_REPL  = 21'h00fffd;
    localparam logic [20:0] CP_SUPP  = 21'h010000;

    typedef enum logic [2:0] {
        K_NONE  = 3'b001,
        K_TERM  = 3'b010,
        K_BYTES = 3'b100
    } kind_t;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } utf8_t;

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t u;
        u.b = '0;
        if (cp < 21'h80) begin
            u.n    = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.n    = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.n    = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.n    = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    // Bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] h;
        case (c) inside
            [8'h30:8'h39]: h = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: h = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: h = {1'b1, 4'(c - 8'h37)};
            default:       h = 5'd0;
        endcase
        return h;
    endfunction

    function automatic logic [LEN_CNT_W-1:0] sat_add(input logic [LEN_CNT_W-1:0] a,
                                                      input logic [2:0] inc);
        logic [LEN_CNT_W:0] sum;
        sum = {1'b0, a} + {{(LEN_CNT_W-2){1'b0}}, inc};
        return sum[LEN_CNT_W] ? {LEN_CNT_W{1'b1}} : sum[LEN_CNT_W-1:0];
    endfunction

    function automatic res_t data_res(input logic [7:0] b);
        res_t r;
        r.data   = b;
        r.valid  = 1'b1;
        r.done   = 1'b0;
        r.status = ST_RUNNING;
        return r;
    endfunction

    function automatic res_t term_res(input logic [2:0] st);
        res_t r;
        r.data   = 8'd0;
        r.valid  = 1'b0;
        r.done   = 1'b1;
        r.status = st;
        return r;
    endfunction

    always_comb
    begin
        state_t               s;
        state_t               nx;
        logic [4:0]           hv;
        logic [15:0]          cp16;
        logic                 is_hi;
        logic                 is_lo;
        logic                 pre_en;
        kind_t                kind;
        logic [2:0]           tstat;
        logic [20:0]          cp;
        logic                 raw;
        logic [7:0]           raw_b;
        utf8_t                u;
        logic [RES_IDX_W-1:0] n;
        logic [LEN_CNT_W-1:0] len;
        logic                 term;
        res_t [RES_DEPTH-1:0] r;

        s = state_cur;
        if (start_of_string)
        begin
            s.mode  = MODE_BODY;
            s.pend  = 1'b0;
            s.acc   = '0;
            s.cnt   = '0;
            s.saved = '0;
            s.len   = '0;
        end

        hv    = hex_val(text_byte);
        cp16  = {s.acc, hv[3:0]};
        is_hi = (cp16[15:10] == 6'b110110);
        is_lo = (cp16[15:10] == 6'b110111);

        nx     = s;
        pre_en = 1'b0;
        kind   = K_NONE;
        tstat  = ST_RUNNING;
        cp     = '0;
        raw    = 1'b0;
        raw_b  = text_byte;

        if (s.mode != MODE_IDLE)
        begin
            if (end_of_text)
            begin
                pre_en = s.pend;
                kind   = K_TERM;
                tstat  = (s.mode == MODE_HEX) ? ST_BAD_UNI : ST_TRUNC;
            end else begin
                case (s.mode)
                    MODE_BODY:
                    begin
                        pre_en = s.pend && (text_byte != CH_BSL);
                        if (text_byte == CH_QUOTE)
                        begin
                            kind  = K_TERM;
                            tstat = ST_CLOSED;
                        end else if (text_byte == CH_BSL)
                        begin
                            nx.mode = MODE_ESC;
                        end else if (text_byte < CTRL_TOP)
                        begin
                            kind  = K_TERM;
                            tstat = ST_CTRL;
                        end else begin
                            kind = K_BYTES;
                            raw  = 1'b1;
                        end
                    end
                    MODE_ESC:
                    begin
                        pre_en  = s.pend && (text_byte != CH_U);
                        nx.mode = MODE_BODY;
                        kind    = K_BYTES;
                        raw     = 1'b1;
                        case (text_byte)
                            CH_QUOTE: raw_b = CH_QUOTE;
                            CH_BSL:   raw_b = CH_BSL;
                            CH_SLASH: raw_b = CH_SLASH;
                            CH_B:     raw_b = 8'h08;
                            CH_F:     raw_b = 8'h0c;
                            CH_N:     raw_b = 8'h0a;
                            CH_R:     raw_b = 8'h0d;
                            CH_T:     raw_b = 8'h09;
                            CH_U:
                            begin
                                nx.mode = MODE_HEX;
                                nx.acc  = '0;
                                nx.cnt  = '0;
                                kind    = K_NONE;
                            end
                            default:
                            begin
                                kind  = K_TERM;
                                tstat = ST_BAD_ESC;
                            end
                        endcase
                    end
                    MODE_HEX:
                    begin
                        if (!hv[4])
                        begin
                            pre_en = s.pend;
                            kind   = K_TERM;
                            tstat  = ST_BAD_UNI;
                        end else if (s.cnt != 2'd3)
                        begin
                            nx.acc = {s.acc[7:0], hv[3:0]};
                            nx.cnt = s.cnt + 2'd1;
                        end else begin
                            nx.mode = MODE_BODY;
                            nx.cnt  = '0;
                            nx.acc  = cp16[11:0];
                            if (s.pend && is_lo)
                            begin
                                // join the pair into one supplementary code point
                                nx.pend = 1'b0;
                                kind    = K_BYTES;
                                cp      = CP_SUPP + {1'b0, s.saved, cp16[9:0]};
                            end else begin
                                pre_en = s.pend;
                                if (is_hi)
                                begin
                                    nx.pend  = 1'b1;
                                    nx.saved = cp16[9:0];
                                end else if (is_lo)
                                begin
                                    kind = K_BYTES;
                                    cp   = CP_REPL;
                                end else begin
                                    kind = K_BYTES;
                                    cp   = {5'd0, cp16};
                                end
                            end
                        end
                    end
                    default:
                    begin
                        nx = s;
                    end
                endcase
            end
        end

        if (pre_en && !(s.mode == MODE_HEX && hv[4] && s.cnt == 2'd3 && is_hi && !end_of_text))
        begin
            nx.pend = 1'b0;
        end

        u = utf8_enc(cp);
        if (raw)
        begin
            u.n    = 3'd1;
            u.b    = '0;
            u.b[0] = raw_b;
        end

        r    = '0;
        n    = '0;
        len  = s.len;
        term = 1'b0;

        // replacement character for an unpaired high surrogate
        if (pre_en)
        begin
            r[0] = data_res(8'hef);
            r[1] = data_res(8'hbf);
            r[2] = data_res(8'hbd);
            n    = RES_IDX_W'(3);
            len  = sat_add(len, 3'd3);
            if (len > {1'b0, max_len})
            begin
                r[3] = term_res(ST_TOO_LONG);
                n    = RES_IDX_W'(4);
                term = 1'b1;
            end
        end

        if (!term)
        begin
            case (kind)
                K_TERM:
                begin
                    r[n] = term_res(tstat);
                    n    = n + RES_IDX_W'(1);
                    term = 1'b1;
                end
                K_BYTES:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < u.n)
                        begin
                            r[n + RES_IDX_W'(i)] = data_res(u.b[i]);
                        end
                    end
                    n   = n + RES_IDX_W'(u.n);
                    len = sat_add(len, u.n);
                    if (len > {1'b0, max_len})
                    begin
                        r[n] = term_res(ST_TOO_LONG);
                        n    = n + RES_IDX_W'(1);
                        term = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        nx.len = len;
        if (term)
        begin
            nx.mode = MODE_IDLE;
            nx.pend = 1'b0;
            nx.acc  = '0;
            nx.cnt  = '0;
        end

        state_next = nx;
        results    = r;
        res_count  = n;
    end

endmodule

/* hdl/json_string_unescape_top.sv */
// Top level of the JSON string unescaper: stream ports, input register,
// decoder state and the result list that drains one output beat per cycle while m_tready is high.
// Depends on jsu_pkg and jsu_decode.
//
// The block takes the body of a JSON string one byte per input beat, the
// first byte flagged by start_of_string. It returns the decoded bytes with
// escapes resolved and \uXXXX escapes written as UTF-8, with surrogate pairs
// joined. A string ends with one result beat that carries string_done and a
// status. m_tlast marks the final result beat of each input beat. An input
// beat that only advances an escape, or that arrives while no string is open,
// yields no output beat at all. An accepted input beat waits in the input
// register until the result list is free, and is then decoded into a result
// list of up to seven beats. The list is registered, and its first beat is
// offered from the result register. The result list drains one beat per
// cycle while m_tready is high, and the next input beat is decoded in the
// cycle the list hands out its final beat. A new input beat is accepted only
// while the input register is empty or its beat is being decoded. The
// length limit may be written at any time the block is idle; cfg_ready is
// always high.
module json_string_unescape_top
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] text_byte
    input  logic [1:0]       s_tuser,     // [0] start_of_string, [1] end_of_text
    // output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,     // [7:0] decoded_byte
    output logic [4:0]       m_tuser,     // [0] byte_valid, [1] string_done, [4:2] status
    output logic             m_tlast,     // last result caused by one input beat
    // length limit register
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_sos_reg;
    logic                 in_eot_reg;

    state_t               state_reg;
    state_t               state_next;
    logic [LEN_W-1:0]     max_len_reg;

    res_t [RES_DEPTH-1:0] res_reg;
    res_t [RES_DEPTH-1:0] res_next;
    logic [RES_IDX_W-1:0] rem_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic [RES_IDX_W-1:0] res_count;

    logic                 out_fire;
    logic                 list_free;
    logic                 consume;
    res_t                 head;

    jsu_decode u_decode (
        .state_cur       (state_reg),
        .text_byte       (in_byte_reg),
        .start_of_string (in_sos_reg),
        .end_of_text     (in_eot_reg),
        .max_len         (max_len_reg),
        .state_next      (state_next),
        .results         (res_next),
        .res_count       (res_count)
    );

    // Decode the held beat once the list is empty or handing out its last beat.
    assign out_fire  = m_tvalid && m_tready;
    assign list_free = (rem_reg == '0) || ((rem_reg == RES_IDX_W'(1)) && m_tready);
    assign consume   = in_valid_reg && list_free;
    assign s_tready  = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    assign head     = res_reg[idx_reg];
    assign m_tvalid = (rem_reg != '0);
    assign m_tlast  = (rem_reg == RES_IDX_W'(1));
    assign m_tdata  = head.data;
    assign m_tuser  = {head.status, head.done, head.valid};

    // Input register: hold the beat until the decoder takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_sos_reg  <= s_tuser[0];
            in_eot_reg  <= s_tuser[1];
        end
    end

    // Decoder state and the length limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= MODE_IDLE;
            state_reg.acc   <= '0;
            state_reg.cnt   <= '0;
            state_reg.pend  <= 1'b0;
            state_reg.saved <= '0;
            state_reg.len   <= '0;
            max_len_reg     <= LEN_W'(MAX_RESET_CFG);
        end else begin
            if (consume)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= LEN_W'(cfg_data);
            end
        end
    end

    // Result list control: load a fresh list, otherwise advance on each taken beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end else if (consume)
        begin
            rem_reg <= res_count;
            idx_reg <= '0;
        end else if (out_fire)
        begin
            rem_reg <= rem_reg - RES_IDX_W'(1);
            idx_reg <= idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* sim/testbench.sv */
// Self-checking bench for json_string_unescape_top: JSON string bodies in, decoded UTF-8 out.
// Depends on jsu_pkg and the RTL; a scoreboard class predicts every decoded beat and checks it.
// Strings are built at random and interleaved with noise, under several length limits.
module testbench
    import jsu_pkg::*;
();

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 16;

    // One expected output beat of the decoder.
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic [2:0] status;
        logic       last;
    } decoded_beat_t;

    // One input beat of the string body.
    typedef struct {
        logic [7:0] text;
        bit         sos;
        bit         eot;
    } text_beat_t;

    // Predicts the decoder beat by beat and holds the decoded beats still owed.
    class unescape_scoreboard;
        decoded_beat_t     decoded_due[$];
        int                fail_count;
        logic [LEN_W-1:0]  limit;
        mode_t             mode;
        logic [15:0]       acc;
        int                digits;
        bit                pend;
        logic [9:0]        saved;
        logic [LEN_CNT_W-1:0] length;
        int                step_results;

        function new();
            fail_count = 0;
            limit      = LEN_W'(MAX_RESET_CFG);
            mode       = MODE_IDLE;
            acc        = '0;
            digits     = 0;
            pend       = 1'b0;
            saved      = '0;
            length     = '0;
        endfunction

        static function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void put(logic [7:0] b, bit v, bit d, logic [2:0] st);
            decoded_beat_t e;
            if (step_results >= RES_DEPTH) return;
            e.data   = b;
            e.valid  = v;
            e.done   = d;
            e.status = st;
            e.last   = 1'b0;
            decoded_due = {decoded_due, e};
            step_results++;
        endfunction

        function void go_idle();
            mode   = MODE_IDLE;
            pend   = 1'b0;
            acc    = '0;
            digits = 0;
        endfunction

        function void fail(logic [2:0] st);
            put(8'h00, 1'b0, 1'b1, st);
            go_idle();
        endfunction

        function void push_byte(logic [7:0] b);
            put(b, 1'b1, 1'b0, ST_RUNNING);
            if (length != {LEN_CNT_W{1'b1}}) length++;
        endfunction

        function bit length_ok();
            if (length > {1'b0, limit}) begin
                fail(ST_TOO_LONG);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit emit_cp(logic [20:0] cp);
            if (cp < 21'h80) begin
                push_byte(cp[7:0]);
            end
            else if (cp < 21'h800) begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else if (cp < 21'h10000) begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
            return length_ok();
        endfunction

        function void body_byte(logic [7:0] c);
            if (c == QUOTE) begin
                put(8'h00, 1'b0, 1'b1, ST_CLOSED);
                go_idle();
            end
            else if (c == BSLASH) begin
                mode = MODE_ESC;
            end
            else if (c < 8'h20) begin
                fail(ST_CTRL);
            end
            else begin
                push_byte(c);
                void'(length_ok());
            end
        endfunction

        function void esc_byte(logic [7:0] c);
            logic [7:0] v;
            case (c)
                QUOTE:  v = QUOTE;
                BSLASH: v = BSLASH;
                "/":    v = "/";
                "b":    v = 8'h08;
                "f":    v = 8'h0C;
                "n":    v = 8'h0A;
                "r":    v = 8'h0D;
                "t":    v = 8'h09;
                "u":
                begin
                    mode   = MODE_HEX;
                    acc    = '0;
                    digits = 0;
                    return;
                end
                default:
                begin
                    fail(ST_BAD_ESC);
                    return;
                end
            endcase
            mode = MODE_BODY;
            push_byte(v);
            void'(length_ok());
        endfunction

        function void resolve_cp(logic [15:0] cp);
            bit is_low;
            is_low = (cp >= 16'hDC00 && cp <= 16'hDFFF);
            mode   = MODE_BODY;
            digits = 0;
            if (pend) begin
                pend = 1'b0;
                // a low half completes the pair: combine into one code point
                if (is_low) begin
                    void'(emit_cp(21'h10000 + {1'b0, saved, cp[9:0]}));
                    return;
                end
                if (!emit_cp(21'hFFFD)) return;
            end
            if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                pend  = 1'b1;
                saved = cp[9:0];
            end
            else if (is_low) begin
                void'(emit_cp(21'hFFFD));
            end
            else begin
                void'(emit_cp({5'd0, cp}));
            end
        endfunction

        function void hex_byte(logic [7:0] c);
            int h;
            h = hex_value(c);
            if (h < 0) begin
                if (pend) begin
                    pend = 1'b0;
                    if (!emit_cp(21'hFFFD)) return;
                end
                fail(ST_BAD_UNI);
                return;
            end
            acc = {acc[11:0], h[3:0]};
            digits++;
            if (digits >= 4) resolve_cp(acc);
        endfunction

        function void end_text();
            logic [2:0] st;
            st = (mode == MODE_HEX) ? ST_BAD_UNI : ST_TRUNC;
            if (pend) begin
                pend = 1'b0;
                if (!emit_cp(21'hFFFD)) return;
            end
            fail(st);
        endfunction

        // Note an accepted input beat; returns 0 when the decoder ignores it.
        function bit note_text_beat(logic [7:0] c, bit sos, bit eot);
            int first;
            first        = decoded_due.size();
            step_results = 0;
            if (sos) begin
                go_idle();
                saved  = '0;
                length = '0;
                mode   = MODE_BODY;
            end
            if (mode == MODE_IDLE) return 1'b0;
            if (eot) begin
                end_text();
            end
            else if (mode == MODE_BODY) begin
                if (pend && c != BSLASH) begin
                    pend = 1'b0;
                    if (emit_cp(21'hFFFD)) body_byte(c);
                end
                else begin
                    body_byte(c);
                end
            end
            else if (mode == MODE_ESC) begin
                if (pend && c != "u") begin
                    pend = 1'b0;
                    if (emit_cp(21'hFFFD)) esc_byte(c);
                end
                else begin
                    esc_byte(c);
                end
            end
            else begin
                hex_byte(c);
            end
            if (decoded_due.size() > first) decoded_due[decoded_due.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        task report_mismatch(string what);
            fail_count++;
            $display("MISMATCH: %s", what);
        endtask

        // Check one accepted output beat against the oldest owed beat.
        task check_decoded_beat(logic [7:0] data, logic [4:0] user, logic last);
            decoded_beat_t e;
            if (decoded_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat data %h user %b last %b",
                                          data, user, last));
                return;
            end
            e = decoded_due.pop_front();
            if (data !== e.data || user[0] !== e.valid || user[1] !== e.done ||
                user[4:2] !== e.status || last !== e.last)
                report_mismatch($sformatf(
                    "got data %h valid %b done %b status %0d last %b, want %h %b %b %0d %b",
                    data, user[0], user[1], user[4:2], last,
                    e.data, e.valid, e.done, e.status, e.last));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;   // [7:0] text_byte
    logic [1:0]       s_tuser   = '0;   // [0] start_of_string, [1] end_of_text
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;          // [7:0] decoded_byte
    logic [4:0]       m_tuser;          // [0] byte_valid, [1] string_done, [4:2] status
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    unescape_scoreboard sb = new();
    text_beat_t script[$];
    bit  steady      = 0;   // no idling on either side while set
    bit  held_once   = 0;
    int  hold_left   = 0;
    int  beats_out   = 0;
    int  phase_items = 0;
    int  quiet       = 0;

    json_string_unescape_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver: stall at random, once hold off for a long stretch so the
    // decoder fills up and pushes back on its input.
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held_once && beats_out >= 60) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else begin
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 23);
        end
    end

    // Sample outputs at the rising edge and check each accepted beat.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_decoded_beat(m_tdata, m_tuser, m_tlast);
            beats_out++;
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_beat(logic [7:0] b, bit sos = 1'b0, bit eot = 1'b0);
        text_beat_t t;
        t.text = b;
        t.sos  = sos;
        t.eot  = eot;
        script = {script, t};
    endfunction

    // Append four hex digits, each in random case.
    function automatic void add_hex4(logic [15:0] v);
        logic [3:0] nib;
        for (int i = 3; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (nib < 4'd10)
                add_beat(8'h30 + nib);
            else
                add_beat(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
        end
    endfunction

    function automatic void add_escape_u(logic [15:0] v);
        add_beat(BSLASH);
        add_beat("u");
        add_hex4(v);
    endfunction

    // Build one string body: optional noise, well-formed pieces, then a
    // closing quote, an error of some kind, or nothing (the next start
    // abandons it).
    function automatic void build_string();
        int start;
        int kind;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 2))
                add_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        start = script.size();
        repeat ($urandom_range(0, 7)) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
                if (b == QUOTE || b == BSLASH) b = "a";
                add_beat(b);
            end
            else if (kind < 40) begin
                add_beat(8'($urandom_range(8'h80, 8'hFF)));
            end
            else if (kind < 55) begin
                add_beat(BSLASH);
                case ($urandom_range(0, 7))
                    0: add_beat(QUOTE);
                    1: add_beat(BSLASH);
                    2: add_beat("/");
                    3: add_beat("b");
                    4: add_beat("f");
                    5: add_beat("n");
                    6: add_beat("r");
                    default: add_beat("t");
                endcase
            end
            else if (kind < 62) add_escape_u(16'($urandom_range(0, 16'h7F)));
            else if (kind < 69) add_escape_u(16'($urandom_range(16'h80, 16'h7FF)));
            else if (kind < 76) add_escape_u(16'($urandom_range(16'h800, 16'hFFFF)));
            else if (kind < 88) begin
                add_escape_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                add_escape_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            else if (kind < 94) add_escape_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            else add_escape_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        kind = $urandom_range(0, 99);
        if (kind < 68) begin
            add_beat(QUOTE);
        end
        else if (kind < 74) begin
            add_beat(8'($urandom_range(0, 8'h1F)));
        end
        else if (kind < 80) begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {QUOTE, BSLASH, "/", "b", "f", "n", "r", "t", "u"});
            add_beat(BSLASH);
            add_beat(b);
        end
        else if (kind < 86) begin
            add_beat(BSLASH);
            add_beat("u");
            repeat ($urandom_range(0, 3)) add_beat(8'(8'h30 + $urandom_range(0, 9)));
            do b = 8'($urandom_range(0, 255));
            while (unescape_scoreboard::hex_value(b) >= 0);
            add_beat(b);
        end
        else if (kind < 92) begin
            add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        else if (kind < 96) begin
            add_beat(BSLASH);
            add_beat("u");
            repeat ($urandom_range(0, 3)) add_beat(8'(8'h30 + $urandom_range(0, 9)));
            add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        if (script.size() == start) add_beat(QUOTE);
        script[start].sos = 1'b1;
    endfunction

    // Offer one beat, idling first at random; hold it until accepted.
    task automatic send_beat(text_beat_t t);
        while (!steady && $urandom_range(0, 99) < 23) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= t.text;
        s_tuser  <= {t.eot, t.sos};
        do @(posedge clk); while (!s_tready);
        if (sb.note_text_beat(t.text, t.sos, t.eot)) phase_items++;
    endtask

    task automatic send_script();
        foreach (script[i]) send_beat(script[i]);
        script.delete();
    endtask

    // Drop valid and wait for every owed beat, then give the decoder time
    // to finish any escape prefix that owes nothing.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.limit = LEN_W'(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_W-1:0] v, int items, bit no_idle);
        settle();
        write_limit(v);
        steady      = no_idle;
        phase_items = 0;
        while (phase_items < items) begin
            build_string();
            send_script();
        end
        steady = 0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings under the reset limit: empty string, ignored idle
        // byte, raw high byte then a control byte, a bad escape, a lone high
        // surrogate cut off by the end of text, and the largest surrogate pair.
        add_beat(QUOTE, 1'b1);
        add_beat("x");
        add_beat(8'hFF, 1'b1);
        add_beat(8'h00);
        add_beat(BSLASH, 1'b1);
        add_beat("q");
        add_beat(BSLASH, 1'b1);
        add_beat("u");
        add_hex4(16'hD800);
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(BSLASH, 1'b1);
        add_beat("u");
        add_hex4(16'hDBFF);
        add_escape_u(16'hDFFF);
        add_beat(QUOTE);
        send_script();

        run_phase(24'hFFFFFF, 45, 1'b0);
        run_phase(24'd0, 15, 1'b0);
        run_phase(24'd5, 30, 1'b0);
        run_phase(CFG_W'($urandom_range(8, 40)), 35, 1'b1);
        run_phase(24'd1, 15, 1'b0);
        run_phase(MAX_RESET_CFG, 60, 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.decoded_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.decoded_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
